// File: design/iu_pkg.sv
// ----------------------------------------------------------------------------
// iu_pkg
// Shared types and constants of the integer pixel upscaler.
// ----------------------------------------------------------------------------
`default_nettype none

package iu_pkg;

  // default sizes of the line buffer and the counters
  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_SCALE_DEF  = 16;
  localparam int MAX_HEIGHT_DEF = 4096;

  // configuration register field widths, pixel and pad widths
  localparam int SCALE_W  = 5;
  localparam int WIDTH_W  = 11;
  localparam int HEIGHT_W = 13;
  localparam int PIXEL_W  = 24;
  localparam int PAD_W    = 2;

  // configuration register indexes
  localparam logic [1:0] REG_SCALE  = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;

  // opcodes of an input item
  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_EMIT = 1'b1
  } opcode_t;

  // input item
  typedef struct packed {
    opcode_t              opcode;
    logic [PIXEL_W-1:0]   src_pixel;
  } in_item_t;

  // result item
  typedef struct packed {
    logic [PIXEL_W-1:0]   out_pixel;
    logic [PAD_W-1:0]     pad_bytes;
    logic                 row_last;
    logic                 frame_last;
  } out_item_t;

  // row and frame markers of an emitted pixel
  typedef struct packed {
    logic [PAD_W-1:0]     pad_bytes;
    logic                 row_last;
    logic                 frame_last;
  } emit_flags_t;

endpackage

`default_nettype wire

// File: design/iu_line_mem.sv
// ----------------------------------------------------------------------------
// iu_line_mem
// Line buffer: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module iu_line_mem #(
  parameter int DEPTH = iu_pkg::MAX_WIDTH_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                       clk,
  input  wire logic                       wr_en,
  input  wire logic [AW-1:0]              wr_addr,
  input  wire logic [iu_pkg::PIXEL_W-1:0] wr_data,
  input  wire logic                       rd_en,
  input  wire logic [AW-1:0]              rd_addr,
  output logic      [iu_pkg::PIXEL_W-1:0] rd_data
);

  logic [iu_pkg::PIXEL_W-1:0] mem [DEPTH];
  logic [iu_pkg::PIXEL_W-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// File: design/iu_ctrl.sv
// ----------------------------------------------------------------------------
// iu_ctrl
// Load and replay counters, buffer addressing and row/frame markers.
// ----------------------------------------------------------------------------
`default_nettype none

module iu_ctrl #(
  parameter int MAX_WIDTH  = iu_pkg::MAX_WIDTH_DEF,
  parameter int MAX_SCALE  = iu_pkg::MAX_SCALE_DEF,
  parameter int MAX_HEIGHT = iu_pkg::MAX_HEIGHT_DEF,
  parameter int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
  parameter int SW = (MAX_SCALE > 1) ? $clog2(MAX_SCALE) : 1,
  parameter int HW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic [iu_pkg::SCALE_W-1:0]  scale,
  input  wire logic [iu_pkg::WIDTH_W-1:0]  src_width,
  input  wire logic [iu_pkg::HEIGHT_W-1:0] src_height,
  input  wire logic                        item_fire,
  input  wire iu_pkg::opcode_t             item_op,
  output logic                             wr_en,
  output logic      [AW-1:0]               wr_addr,
  output logic                             rd_en,
  output logic      [AW-1:0]               rd_addr,
  output iu_pkg::emit_flags_t              flags
);

  logic [AW-1:0] wr_idx_r, wr_idx_nxt;
  logic [AW-1:0] rd_idx_r, rd_idx_nxt;
  logic [SW-1:0] pix_rep_r, pix_rep_nxt;
  logic [SW-1:0] row_rep_r, row_rep_nxt;
  logic [HW-1:0] src_row_r, src_row_nxt;
  logic          replay_r, replay_nxt;

  logic [SW-1:0] s_last;
  logic [AW-1:0] w_last;
  logic [HW-1:0] h_last;
  logic          load, emit;
  logic          pix_end, col_end, rep_end, src_end, row_last;
  logic [AW:0]   w_cnt;
  logic [SW:0]   s_cnt;
  logic [3:0]    pad_prod;

  // last counter positions from the clamped registers
  always_comb begin
    if (scale == '0) begin
      s_last = '0;
    end else if (scale > MAX_SCALE) begin
      s_last = SW'(MAX_SCALE - 1);
    end else begin
      s_last = SW'(scale - 1'b1);
    end
    if (src_width == '0) begin
      w_last = '0;
    end else if (src_width > MAX_WIDTH) begin
      w_last = AW'(MAX_WIDTH - 1);
    end else begin
      w_last = AW'(src_width - 1'b1);
    end
    if (src_height == '0) begin
      h_last = '0;
    end else if (src_height > MAX_HEIGHT) begin
      h_last = HW'(MAX_HEIGHT - 1);
    end else begin
      h_last = HW'(src_height - 1'b1);
    end
  end

  assign load = item_fire && (item_op == iu_pkg::OP_LOAD) && !replay_r;
  assign emit = item_fire && (item_op == iu_pkg::OP_EMIT) && replay_r;

  // end-of-count conditions
  assign pix_end  = pix_rep_r >= s_last;
  assign col_end  = rd_idx_r >= w_last;
  assign rep_end  = row_rep_r >= s_last;
  assign src_end  = src_row_r >= h_last;
  assign row_last = pix_end && col_end;

  // pad bytes: (width * scale) mod 4 from the low bits of each factor
  assign w_cnt    = {1'b0, w_last} + 1'b1;
  assign s_cnt    = {1'b0, s_last} + 1'b1;
  assign pad_prod = {2'b00, w_cnt[1:0]} * {2'b00, s_cnt[1:0]};

  always_comb begin
    flags.pad_bytes  = row_last ? pad_prod[1:0] : '0;
    flags.row_last   = row_last;
    flags.frame_last = row_last && rep_end && src_end;
  end

  // buffer ports
  assign wr_en   = load;
  assign wr_addr = wr_idx_r;
  assign rd_en   = emit;
  assign rd_addr = rd_idx_r;

  // counter next values
  always_comb begin
    wr_idx_nxt  = wr_idx_r;
    rd_idx_nxt  = rd_idx_r;
    pix_rep_nxt = pix_rep_r;
    row_rep_nxt = row_rep_r;
    src_row_nxt = src_row_r;
    replay_nxt  = replay_r;
    if (load) begin
      if (wr_idx_r >= w_last) begin
        wr_idx_nxt = '0;
        replay_nxt = 1'b1;
      end else begin
        wr_idx_nxt = wr_idx_r + 1'b1;
      end
    end
    if (emit) begin
      if (!pix_end) begin
        pix_rep_nxt = pix_rep_r + 1'b1;
      end else begin
        pix_rep_nxt = '0;
        if (!col_end) begin
          rd_idx_nxt = rd_idx_r + 1'b1;
        end else begin
          rd_idx_nxt = '0;
          if (!rep_end) begin
            row_rep_nxt = row_rep_r + 1'b1;
          end else begin
            row_rep_nxt = '0;
            replay_nxt  = 1'b0;
            src_row_nxt = src_end ? '0 : src_row_r + 1'b1;
          end
        end
      end
    end
  end

  // counter registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_idx_r  <= '0;
      rd_idx_r  <= '0;
      pix_rep_r <= '0;
      row_rep_r <= '0;
      src_row_r <= '0;
      replay_r  <= 1'b0;
    end else begin
      wr_idx_r  <= wr_idx_nxt;
      rd_idx_r  <= rd_idx_nxt;
      pix_rep_r <= pix_rep_nxt;
      row_rep_r <= row_rep_nxt;
      src_row_r <= src_row_nxt;
      replay_r  <= replay_nxt;
    end
  end

endmodule

`default_nettype wire

// File: design/integer_pixel_upscaler.sv
// ----------------------------------------------------------------------------
// integer_pixel_upscaler
// Nearest-neighbor integer upscaler for 24-bit pixels with a line buffer.
// ----------------------------------------------------------------------------
// One input transfer is taken per clock cycle, loads and emits alike, as long
// as the result path drains. The line buffer has one write port and one read
// port; an emit reads it at acceptance, and the pixel passes from the read
// register to the output register, which drives out_valid and out_data. The
// output register and the read stage together hold two results before
// in_stall rises. Loads given during replay and emits given during loading
// are taken and give no result. The buffer needs no clearing after reset.
`default_nettype none

module integer_pixel_upscaler #(
  parameter int MAX_WIDTH  = iu_pkg::MAX_WIDTH_DEF,
  parameter int MAX_SCALE  = iu_pkg::MAX_SCALE_DEF,
  parameter int MAX_HEIGHT = iu_pkg::MAX_HEIGHT_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  // input channel
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire iu_pkg::in_item_t in_data,
  // result channel
  output logic                  out_valid,
  input  wire logic             out_stall,
  output iu_pkg::out_item_t     out_data,
  // configuration port
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [3:0]       paddr,
  input  wire logic [31:0]      pwdata,
  output logic      [31:0]      prdata,
  output logic                  pready
);

  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

  logic [iu_pkg::SCALE_W-1:0]  scale_r;
  logic [iu_pkg::WIDTH_W-1:0]  width_r;
  logic [iu_pkg::HEIGHT_W-1:0] height_r;
  logic                        cfg_wr;
  logic [1:0]                  reg_idx;

  logic                        item_fire;
  logic                        wr_en, rd_en;
  logic [AW-1:0]               wr_addr, rd_addr;
  logic [iu_pkg::PIXEL_W-1:0]  rd_data;
  iu_pkg::emit_flags_t         flags;

  logic                        s1_valid_r, s1_valid_nxt;
  iu_pkg::emit_flags_t         s1_flags_r;
  logic                        s1_move;
  logic                        out_valid_r, out_valid_nxt;
  iu_pkg::out_item_t           out_data_r;

  // configuration registers
  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r  <= iu_pkg::SCALE_W'(1);
      width_r  <= iu_pkg::WIDTH_W'(1);
      height_r <= iu_pkg::HEIGHT_W'(1);
    end else if (cfg_wr) begin
      unique case (reg_idx)
        iu_pkg::REG_SCALE:  scale_r  <= pwdata[iu_pkg::SCALE_W-1:0];
        iu_pkg::REG_WIDTH:  width_r  <= pwdata[iu_pkg::WIDTH_W-1:0];
        iu_pkg::REG_HEIGHT: height_r <= pwdata[iu_pkg::HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (reg_idx)
      iu_pkg::REG_SCALE:  prdata = 32'(scale_r);
      iu_pkg::REG_WIDTH:  prdata = 32'(width_r);
      iu_pkg::REG_HEIGHT: prdata = 32'(height_r);
      default:            prdata = '0;
    endcase
  end

  // input transfer: blocked only while the read stage cannot drain
  assign s1_move   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && !s1_move;
  assign item_fire = in_valid && !in_stall;

  iu_ctrl #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_SCALE  (MAX_SCALE),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .scale      (scale_r),
    .src_width  (width_r),
    .src_height (height_r),
    .item_fire  (item_fire),
    .item_op    (in_data.opcode),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .flags      (flags)
  );

  iu_line_mem #(
    .DEPTH (MAX_WIDTH)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (in_data.src_pixel),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // read stage: markers wait here alongside the buffer read
  always_comb begin
    if (rd_en) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_move) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      s1_flags_r <= flags;
    end
  end

  // output register
  always_comb begin
    if (s1_move) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_data_r.out_pixel  <= rd_data;
      out_data_r.pad_bytes  <= s1_flags_r.pad_bytes;
      out_data_r.row_last   <= s1_flags_r.row_last;
      out_data_r.frame_last <= s1_flags_r.frame_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire
